// ----- hdl/sbus_frame_receiver_assert.svh -----
// assertion macros for the sbus frame receiver controller
`ifndef SBUS_FRAME_RECEIVER_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_ASSERT_SVH

// condition must never hold outside reset
`define SBFR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SBFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sbfr_pkg.sv -----
// types and constants of the sbus frame receiver
`default_nettype none

package sbfr_pkg;

  // word field widths
  localparam int RX_BYTE_W   = 8;
  localparam int CHAN_IDX_W  = 4;
  localparam int CHAN_BITS   = 11;

  // framing bytes
  localparam logic [RX_BYTE_W-1:0] HEADER_BYTE = 8'h0F;
  localparam logic [RX_BYTE_W-1:0] END_BYTE    = 8'h00;

  // bit positions inside the flag byte
  localparam int FLAG_LOST_BIT     = 2;
  localparam int FLAG_FAILSAFE_BIT = 3;
  localparam int FLAG_SW1_BIT      = 4;
  localparam int FLAG_SW2_BIT      = 5;

  // controller states
  typedef enum logic [1:0] {
    ST_HUNT,
    ST_PAYLOAD,
    ST_END,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic                  load_data;
    logic                  load_flag;
    logic                  shift_chan;
    logic [CHAN_IDX_W-1:0] chan_idx;
    logic                  last;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_header;
    logic is_end;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/sbfr_ifs.sv -----
// input byte and channel result channel interfaces
`default_nettype none

interface sbfr_in_if;
  import sbfr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RX_BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfr_out_if;
  import sbfr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CHAN_IDX_W-1:0] channel_index;
  logic [CHAN_BITS-1:0]  channel_value;
  logic                  frame_lost;
  logic                  failsafe_active;
  logic                  switch_one;
  logic                  switch_two;
  logic                  last_channel;

  modport source (
    output valid, output channel_index, output channel_value, output frame_lost,
    output failsafe_active, output switch_one, output switch_two, output last_channel,
    input ready
  );
  modport sink (
    input valid, input channel_index, input channel_value, input frame_lost,
    input failsafe_active, input switch_one, input switch_two, input last_channel,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/sbus_frame_receiver.sv -----
// Sbus frame receiver top level: controller plus payload datapath.
// Every byte is taken in the cycle it is offered while hunting or collecting.
// The first channel word is valid the cycle after a good end byte is taken;
// the sixteen words then follow one per cycle while out_ch.ready is high,
// and no byte is taken until the last word has been delivered.
// Synchronous active-low reset returns to header hunt; payload bytes are not reset.
`default_nettype none

module sbus_frame_receiver #(
  parameter int CHANNEL_COUNT = 16,
  parameter int FRAME_BYTES   = 25
) (
  input wire          clk,
  input wire          rst_n,
  sbfr_in_if.sink     in_ch,
  sbfr_out_if.source  out_ch
);
  import sbfr_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // frame controller
  sbfr_ctrl #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // payload storage and channel unpacking
  sbfr_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rx_byte         (in_ch.rx_byte),
    .cmd             (cmd),
    .status          (status),
    .channel_index   (out_ch.channel_index),
    .channel_value   (out_ch.channel_value),
    .frame_lost      (out_ch.frame_lost),
    .failsafe_active (out_ch.failsafe_active),
    .switch_one      (out_ch.switch_one),
    .switch_two      (out_ch.switch_two),
    .last_channel    (out_ch.last_channel)
  );

endmodule

`default_nettype wire

// ----- hdl/sbfr_datapath.sv -----
// payload shift register, flag byte and channel extraction
`default_nettype none

module sbfr_datapath #(
  parameter int CHANNEL_COUNT = 16,
  parameter int FRAME_BYTES   = 25
) (
  input  wire                                   clk,
  input  wire  [sbfr_pkg::RX_BYTE_W-1:0]        rx_byte,
  input  wire  sbfr_pkg::ctl_cmd_t              cmd,
  output sbfr_pkg::dp_status_t                  status,
  output logic [sbfr_pkg::CHAN_IDX_W-1:0]       channel_index,
  output logic [sbfr_pkg::CHAN_BITS-1:0]        channel_value,
  output logic                                  frame_lost,
  output logic                                  failsafe_active,
  output logic                                  switch_one,
  output logic                                  switch_two,
  output logic                                  last_channel
);
  import sbfr_pkg::*;

  // data bytes between header and flag byte
  localparam int DATA_BYTES = FRAME_BYTES - 3;
  localparam int DATA_W     = DATA_BYTES * RX_BYTE_W;
  localparam int CHAN_SPAN  = CHANNEL_COUNT * CHAN_BITS;

  logic [DATA_W-1:0]    data_r;
  logic [DATA_W-1:0]    data_nxt;
  logic [RX_BYTE_W-1:0] flag_r;

  // byte compares for the controller
  assign status.is_header = (rx_byte == HEADER_BYTE);
  assign status.is_end    = (rx_byte == END_BYTE);

  // new bytes enter at the top so the first byte ends up at bit 0;
  // each delivered word drops the lowest channel
  always_comb begin
    data_nxt = data_r;
    if (cmd.load_data) begin
      data_nxt = {rx_byte, data_r[DATA_W-1:RX_BYTE_W]};
    end else if (cmd.shift_chan) begin
      data_nxt = {{CHAN_BITS{1'b0}}, data_r[DATA_W-1:CHAN_BITS]};
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.load_flag) begin
      flag_r <= rx_byte;
    end
  end

  // result word fields
  assign channel_index   = cmd.chan_idx;
  assign channel_value   = data_r[CHAN_BITS-1:0];
  assign frame_lost      = flag_r[FLAG_LOST_BIT];
  assign failsafe_active = flag_r[FLAG_FAILSAFE_BIT];
  assign switch_one      = flag_r[FLAG_SW1_BIT];
  assign switch_two      = flag_r[FLAG_SW2_BIT];
  assign last_channel    = cmd.last;

  // channels must exactly fill the data bytes
  if (CHAN_SPAN != DATA_W) begin : g_bad_geometry
    $error("channel bits do not match data bytes");
  end

endmodule

`default_nettype wire

// ----- hdl/sbfr_ctrl.sv -----
// frame controller: header hunt, byte count and channel sequencing
`default_nettype none
`include "sbus_frame_receiver_assert.svh"

module sbfr_ctrl #(
  parameter int CHANNEL_COUNT = 16,
  parameter int FRAME_BYTES   = 25
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire                       out_ready,
  input  wire  sbfr_pkg::dp_status_t status,
  output sbfr_pkg::ctl_cmd_t        cmd
);
  import sbfr_pkg::*;

  localparam int PAYLOAD_LEN = FRAME_BYTES - 2;
  localparam int CNT_W       = $clog2(PAYLOAD_LEN);
  localparam int CHAN_W      = $clog2(CHANNEL_COUNT);
  localparam logic [CNT_W-1:0]  FLAG_IDX  = CNT_W'(PAYLOAD_LEN - 1);
  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNEL_COUNT - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    chan_nxt  = chan_r;
    case (state_r)
      ST_HUNT: begin
        if (in_acc && status.is_header) begin
          state_nxt = ST_PAYLOAD;
          cnt_nxt   = '0;
        end
      end
      ST_PAYLOAD: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == FLAG_IDX) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (in_acc) begin
          cnt_nxt   = '0;
          chan_nxt  = '0;
          state_nxt = status.is_end ? ST_EMIT : ST_HUNT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          chan_nxt = chan_r + 1'b1;
          if (chan_r == LAST_CHAN) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // handshake and datapath commands
  always_comb begin
    in_ready       = (state_r != ST_EMIT);
    out_valid      = (state_r == ST_EMIT);
    cmd.load_data  = in_acc && (state_r == ST_PAYLOAD) && (cnt_r != FLAG_IDX);
    cmd.load_flag  = in_acc && (state_r == ST_PAYLOAD) && (cnt_r == FLAG_IDX);
    cmd.shift_chan = out_acc;
    cmd.chan_idx   = CHAN_IDX_W'(chan_r);
    cmd.last       = (chan_r == LAST_CHAN);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      cnt_r   <= '0;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chan_r  <= chan_nxt;
    end
  end

  // checks
  `SBFR_ASSERT_NEVER(a_no_in_during_emit, in_ready && out_valid, "byte taken while emitting")
  `SBFR_ASSERT_NEXT(a_good_end_starts_emit,
    in_acc && (state_r == ST_END) && status.is_end,
    out_valid && (chan_r == '0), "good end byte did not start channel 0")
  `SBFR_ASSERT_NEXT(a_last_word_resumes_hunt, out_acc && cmd.last,
    in_ready && (state_r == ST_HUNT), "no return to hunt after last channel")
  `SBFR_ASSERT_NEVER(a_count_in_range, (state_r == ST_PAYLOAD) && (cnt_r > FLAG_IDX),
    "byte count past flag byte")

endmodule

`default_nettype wire
